@@ rtl/mpq_pkg.sv @@
// ----------------------------------------------------------------------------
// mpq_pkg
// Shared types and codes for the sorted-list minimum priority queue.
// ----------------------------------------------------------------------------
package mpq_pkg;

    // payload widths
    localparam int ID_W     = 16;
    localparam int URG_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // operation codes
    typedef enum logic [0:0] {
        OP_PUSH  = 1'b0,
        OP_SERVE = 1'b1
    } t_opcode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

endpackage

@@ rtl/min_priority_queue.sv @@
// ----------------------------------------------------------------------------
// min_priority_queue: sorted-list minimum priority queue, push and serve
// Each operation is captured, then executed into the result registers; the
// result is held until taken, and no new input is accepted before that.
// Sync reset empties the queue and the handshake; entry storage not cleared.
// ----------------------------------------------------------------------------
module min_priority_queue
    import mpq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_opcode,
    input  logic [ID_W-1:0]     i_entry_id,
    input  logic [URG_W-1:0]    i_urgency,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [ID_W-1:0]     o_served_id,
    output logic [STATUS_W-1:0] o_status,
    output logic [OCC_W-1:0]    o_occupancy
);

    t_dp_cmd w_cmd;

    // sequencer
    mpq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // entry cells and result registers
    mpq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_opcode    (i_opcode),
        .i_entry_id  (i_entry_id),
        .i_urgency   (i_urgency),
        .o_served_id (o_served_id),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

endmodule

@@ rtl/mpq_datapath.sv @@
// ----------------------------------------------------------------------------
// mpq_datapath
// Row of sorted entry cells with parallel compare and shift, entry count
// and result registers.
// ----------------------------------------------------------------------------
module mpq_datapath
    import mpq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic              i_opcode,
    input  logic [ID_W-1:0]   i_entry_id,
    input  logic [URG_W-1:0]  i_urgency,
    output logic [ID_W-1:0]   o_served_id,
    output logic [STATUS_W-1:0] o_status,
    output logic [OCC_W-1:0]  o_occupancy
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    // captured operation
    t_opcode           r_op;
    logic [ID_W-1:0]   r_id;
    logic [URG_W-1:0]  r_urg;

    // entry cells, kept in service order
    logic [ID_W-1:0]   r_ids  [DEPTH];
    logic [URG_W-1:0]  r_urgs [DEPTH];
    logic [ID_W-1:0]   n_ids  [DEPTH];
    logic [URG_W-1:0]  n_urgs [DEPTH];

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    // result registers
    logic [ID_W-1:0]   r_served_id;
    logic [ID_W-1:0]   n_served_id;
    t_status           r_status;
    t_status           n_status;

    logic              w_full;
    logic              w_empty;
    logic [DEPTH-1:0]  w_le;

    assign w_full  = (r_count == CNT_W'(DEPTH));
    assign w_empty = (r_count == '0);

    // capture the operation on transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_opcode'(i_opcode);
            r_id  <= i_entry_id;
            r_urg <= i_urgency;
        end
    end

    // per-cell next value
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic              w_prev_le;
        logic [ID_W-1:0]   w_prev_id;
        logic [URG_W-1:0]  w_prev_urg;
        logic [ID_W-1:0]   w_next_id;
        logic [URG_W-1:0]  w_next_urg;

        // held entry ahead of the new one: valid and at least as urgent (urgency not greater)
        assign w_le[k] = (CNT_W'(k) < r_count) && (r_urgs[k] <= r_urg);

        if (k == 0) begin : g_head
            assign w_prev_le  = 1'b1;
            assign w_prev_id  = r_ids[k];
            assign w_prev_urg = r_urgs[k];
        end else begin : g_body
            assign w_prev_le  = w_le[k-1];
            assign w_prev_id  = r_ids[k-1];
            assign w_prev_urg = r_urgs[k-1];
        end

        if (k == DEPTH - 1) begin : g_tail
            assign w_next_id  = r_ids[k];
            assign w_next_urg = r_urgs[k];
        end else begin : g_inner
            assign w_next_id  = r_ids[k+1];
            assign w_next_urg = r_urgs[k+1];
        end

        always_comb begin
            n_ids[k]  = r_ids[k];
            n_urgs[k] = r_urgs[k];
            if (r_op == OP_PUSH) begin
                if (!w_full && !w_le[k]) begin
                    if (w_prev_le) begin
                        n_ids[k]  = r_id;
                        n_urgs[k] = r_urg;
                    end else begin
                        n_ids[k]  = w_prev_id;
                        n_urgs[k] = w_prev_urg;
                    end
                end
            end else if (!w_empty) begin
                n_ids[k]  = w_next_id;
                n_urgs[k] = w_next_urg;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.execute) begin
                r_ids[k]  <= n_ids[k];
                r_urgs[k] <= n_urgs[k];
            end
        end
    end

    // count and result
    always_comb begin
        n_count     = r_count;
        n_served_id = '0;
        n_status    = ST_OK;
        if (r_op == OP_PUSH) begin
            if (w_full) begin
                n_status = ST_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end else begin
            if (w_empty) begin
                n_status = ST_EMPTY;
            end else begin
                n_count     = r_count - CNT_W'(1);
                n_served_id = r_ids[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.execute) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_served_id <= n_served_id;
            r_status    <= n_status;
        end
    end

    assign o_served_id = r_served_id;
    assign o_status    = r_status;

    // occupancy reported in five bits
    if (CNT_W >= OCC_W) begin : g_occ_trim
        assign o_occupancy = r_count[OCC_W-1:0];
    end else begin : g_occ_pad
        assign o_occupancy = {{(OCC_W - CNT_W){1'b0}}, r_count};
    end

endmodule

@@ rtl/mpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// mpq_ctrl
// Operation sequencer: accept, execute, then hold the result until taken.
// ----------------------------------------------------------------------------
module mpq_ctrl
    import mpq_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state       = r_state;
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.execute = 1'b1;
                n_state       = S_RESP;
            end
            S_RESP: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
